// ===== hdl/sss_pkg.sv =====
// Package for the state-space step unit: fixed-point types, op and bank codes,
// register indexes and the rounding/saturation helpers. No dependencies.
package sss_pkg;

  localparam int QW = 24;
  localparam int QF = 12;
  localparam int ACCW = 48;
  localparam int CNTW = 16;
  localparam int MAX_STATES_DEF = 4;
  localparam int MAX_INPUTS_DEF = 4;
  localparam int MAX_OUTPUTS_DEF = 4;
  localparam int NUM_U = 4;
  localparam int NUM_Y = 4;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [ACCW-1:0] acc_t;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_RESTART = 2'd1,
    OP_STEP    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BANK_A  = 2'd0,
    BANK_B  = 2'd1,
    BANK_C  = 2'd2,
    BANK_X0 = 2'd3
  } bank_t;

  typedef enum logic [1:0] {
    REG_STATES  = 2'd0,
    REG_INPUTS  = 2'd1,
    REG_OUTPUTS = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XMAC,
    ST_YMAC,
    ST_OUT
  } state_t;

  // Lane control shared by the sequencer and the lanes.
  typedef struct packed {
    logic clear;
    logic enable;
  } lane_ctl_t;

  // Round a Q23.24 product half up to 12 fractional bits (arithmetic shift is floor).
  function automatic acc_t qround(input logic signed [2*QW-1:0] p);
    logic signed [2*QW-1:0] t;
    begin
      t = p + (2*QW)'(1 << (QF - 1));
      qround = acc_t'(t >>> QF);
    end
  endfunction

  function automatic q_t qsat(input acc_t v);
    begin
      if (v > acc_t'(8388607)) qsat = q_t'(8388607);
      else if (v < -acc_t'(8388608)) qsat = q_t'(-8388608);
      else qsat = q_t'(v);
    end
  endfunction

endpackage

// ===== hdl/sss_lane.sv =====
// One multiply-accumulate lane: a registered product followed by an exact wide sum.
// Depends on sss_pkg.
module sss_lane (
  input  logic              clk,
  input  sss_pkg::lane_ctl_t ctl,
  input  sss_pkg::q_t       coef,
  input  sss_pkg::q_t       operand,
  output sss_pkg::acc_t     acc
);
  import sss_pkg::*;

  logic signed [2*QW-1:0] prod;
  logic                   prod_vld;

  always_ff @(posedge clk) begin
    prod <= coef * operand;
    prod_vld <= ctl.enable;
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + qround(prod);
    end
  end

endmodule

// ===== hdl/state_space_system_step_unit.sv =====
// Top level of the state-space step unit: handshakes, APB registers, coefficient
// stores, sequencer and merge stage. Depends on sss_pkg and sss_lane.
//
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/in_stall | op, coef_*, u0..u3
// out     | output    | out_valid/out_stall | y0..y3, time_step
// cfg     | input     | APB psel/penable | active_states/inputs/outputs
//
// A write word does not stall the input. After a restart is accepted the input
// stays stalled through ST_YMAC and ST_OUT; after a step, through ST_XMAC,
// ST_YMAC and ST_OUT. Each lane has a single multiply-add and walks one column
// per cycle. One lane per state row does x' and the same lanes (one per output
// row) then do y. Reset clears the stores but for uv, and the state, counter
// and control. A
// finished word waits in the output register while the next input word is
// already accepted; if it still waits when the next result is ready, the
// sequencer holds in its last cycle and the input stays stalled.
module state_space_system_step_unit #(
  parameter int MAX_STATES  = sss_pkg::MAX_STATES_DEF,
  parameter int MAX_INPUTS  = sss_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = sss_pkg::MAX_OUTPUTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [1:0]        coef_bank,
  input  logic [1:0]        coef_row,
  input  logic [1:0]        coef_col,
  input  sss_pkg::q_t       coef_value,
  input  sss_pkg::q_t       u0,
  input  sss_pkg::q_t       u1,
  input  sss_pkg::q_t       u2,
  input  sss_pkg::q_t       u3,
  output logic              out_valid,
  input  logic              out_stall,
  output sss_pkg::q_t       y0,
  output sss_pkg::q_t       y1,
  output sss_pkg::q_t       y2,
  output sss_pkg::q_t       y3,
  output logic [15:0]       time_step,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import sss_pkg::*;

  localparam int NL = (MAX_STATES > MAX_OUTPUTS) ? MAX_STATES : MAX_OUTPUTS;
  localparam int KMAX = MAX_STATES + MAX_INPUTS;
  localparam int KW = $clog2(KMAX + 4);

  // Configuration registers.
  logic [2:0] active_states, active_inputs, active_outputs;
  reg_idx_t   reg_sel;
  assign pready = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_states <= 3'd4;
      active_inputs <= 3'd4;
      active_outputs <= 3'd4;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_STATES:  active_states <= pwdata[2:0];
        REG_INPUTS:  active_inputs <= pwdata[2:0];
        REG_OUTPUTS: active_outputs <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_STATES:  prdata = {29'd0, active_states};
      REG_INPUTS:  prdata = {29'd0, active_inputs};
      REG_OUTPUTS: prdata = {29'd0, active_outputs};
      default:     prdata = '0;
    endcase
  end

  // Effective counts: zero acts as one, large values clamp to the size.
  function automatic logic [KW-1:0] eff(input logic [2:0] r, input int mx);
    begin
      if (r == 3'd0) eff = KW'(1);
      else if (int'(r) > mx) eff = KW'(mx);
      else eff = KW'(r);
    end
  endfunction

  logic [KW-1:0] ns, ni, no;
  assign ns = eff(active_states, MAX_STATES);
  assign ni = eff(active_inputs, MAX_INPUTS);
  assign no = eff(active_outputs, MAX_OUTPUTS);

  // Coefficient stores and state.
  q_t a_m [MAX_STATES][MAX_STATES];
  q_t b_m [MAX_STATES][MAX_INPUTS];
  q_t c_m [MAX_OUTPUTS][MAX_STATES];
  q_t x0  [MAX_STATES];
  q_t xv  [MAX_STATES];
  q_t uv  [MAX_INPUTS];
  logic [CNTW-1:0] step_count;

  state_t state, state_next;
  logic [KW-1:0] k, k_next;
  logic is_step, out_pend;
  logic accept_in, out_load, xdone;
  lane_ctl_t ctl;
  acc_t acc [NL];
  q_t coef_l [NL];
  q_t opnd;

  assign in_stall = (state != ST_IDLE);
  assign accept_in = in_valid && !in_stall;

  // Sequencer: k walks the columns, then runs on past the last one to drain the product register.
  always_comb begin
    state_next = state;
    k_next = k;
    ctl = '{clear: 1'b0, enable: 1'b0};
    out_load = 1'b0;
    xdone = 1'b0;
    unique case (state)
      ST_IDLE: begin
        k_next = '0;
        ctl.clear = 1'b1;
        if (accept_in && op == OP_STEP) state_next = ST_XMAC;
        else if (accept_in && op == OP_RESTART) state_next = ST_YMAC;
      end
      ST_XMAC: begin
        ctl.enable = (k < ns + ni);
        k_next = k + KW'(1);
        if (k == ns + ni + KW'(1)) begin
          xdone = 1'b1;
          k_next = '0;
          ctl.clear = 1'b1;
          state_next = ST_YMAC;
        end
      end
      ST_YMAC: begin
        ctl.enable = (k < ns);
        k_next = k + KW'(1);
        if (k == ns + KW'(1)) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_pend || !out_stall) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k <= '0;
      step_count <= '0;
      is_step <= 1'b0;
    end else begin
      state <= state_next;
      k <= k_next;
      if (accept_in && op == OP_RESTART) step_count <= '0;
      if (accept_in && op == OP_STEP) step_count <= step_count + CNTW'(1);
      if (accept_in) is_step <= (op == OP_STEP);
    end
  end

  // Stores: write items, restart copy and the step's state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_STATES; r++) begin
        x0[r] <= '0;
        xv[r] <= '0;
        for (int c = 0; c < MAX_STATES; c++) a_m[r][c] <= '0;
        for (int c = 0; c < MAX_INPUTS; c++) b_m[r][c] <= '0;
      end
      for (int r = 0; r < MAX_OUTPUTS; r++)
        for (int c = 0; c < MAX_STATES; c++) c_m[r][c] <= '0;
    end else begin
      if (accept_in && op == OP_WRITE) begin
        for (int r = 0; r < MAX_STATES; r++) begin
          if (int'(coef_row) == r) begin
            if (coef_bank == BANK_X0) x0[r] <= coef_value;
            for (int c = 0; c < MAX_STATES; c++)
              if (coef_bank == BANK_A && int'(coef_col) == c) a_m[r][c] <= coef_value;
            for (int c = 0; c < MAX_INPUTS; c++)
              if (coef_bank == BANK_B && int'(coef_col) == c) b_m[r][c] <= coef_value;
          end
        end
        for (int r = 0; r < MAX_OUTPUTS; r++)
          for (int c = 0; c < MAX_STATES; c++)
            if (coef_bank == BANK_C && int'(coef_row) == r && int'(coef_col) == c)
              c_m[r][c] <= coef_value;
      end
      if (accept_in && op == OP_RESTART) begin
        for (int r = 0; r < MAX_STATES; r++)
          xv[r] <= (KW'(r) < ns) ? x0[r] : '0;
      end
      if (xdone) begin
        for (int r = 0; r < MAX_STATES; r++)
          xv[r] <= (KW'(r) < ns) ? qsat(acc[r]) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in && op == OP_STEP) begin
      for (int j = 0; j < MAX_INPUTS; j++) begin
        case (j)
          0: uv[j] <= u0;
          1: uv[j] <= u1;
          2: uv[j] <= u2;
          3: uv[j] <= u3;
          default: uv[j] <= '0;
        endcase
      end
    end
  end

  // Column operand and per-lane coefficient for the current k.
  always_comb begin
    opnd = '0;
    for (int j = 0; j < MAX_STATES; j++)
      if (k == KW'(j)) opnd = xv[j];
    if (state == ST_XMAC) begin
      for (int j = 0; j < MAX_INPUTS; j++)
        if (k == ns + KW'(j)) opnd = uv[j];
    end
    for (int l = 0; l < NL; l++) begin
      coef_l[l] = '0;
      if (state == ST_XMAC && l < MAX_STATES) begin
        for (int j = 0; j < MAX_STATES; j++)
          if (k == KW'(j) && KW'(j) < ns) coef_l[l] = a_m[l][j];
        for (int j = 0; j < MAX_INPUTS; j++)
          if (k == ns + KW'(j)) coef_l[l] = b_m[l][j];
      end else if (l < MAX_OUTPUTS) begin
        for (int j = 0; j < MAX_STATES; j++)
          if (k == KW'(j)) coef_l[l] = c_m[l][j];
      end
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    sss_lane u_lane (
      .clk(clk), .ctl(ctl), .coef(coef_l[l]), .operand(opnd), .acc(acc[l])
    );
  end

  // Merge stage: saturate the output rows into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_pend <= 1'b0;
    end else if (out_load) begin
      out_pend <= 1'b1;
    end else if (!out_stall) begin
      out_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      y0 <= (no > KW'(0) && MAX_OUTPUTS > 0) ? qsat(acc[0]) : '0;
      y1 <= (no > KW'(1) && MAX_OUTPUTS > 1) ? qsat(acc[NL > 1 ? 1 : 0]) : '0;
      y2 <= (no > KW'(2) && MAX_OUTPUTS > 2) ? qsat(acc[NL > 2 ? 2 : 0]) : '0;
      y3 <= (no > KW'(3) && MAX_OUTPUTS > 3) ? qsat(acc[NL > 3 ? 3 : 0]) : '0;
      time_step <= step_count;
    end
  end

  assign out_valid = out_pend;

`ifndef SYNTH
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_pend || !out_stall)) else $error("output overwritten");
  a_xdone_step: assert property (@(posedge clk) disable iff (rst)
    xdone |-> is_step) else $error("state update outside a step");
  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
    (accept_in && op == OP_RESTART) |=> (step_count == '0)) else $error("counter not cleared");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for state_space_system_step_unit: random coefficient loads,
// restarts and steps with a fixed-point predictor. Depends on sss_pkg and the RTL.
module tb;
  import sss_pkg::*;

  // Output word as the predictor computes it.
  typedef struct {
    logic signed [23:0] y [4];
    logic [15:0] ts;
  } yword_t;

  // Predicts each output word and checks the block's output against it.
  class ss_scoreboard;
    logic signed [23:0] a_m [4][4];
    logic signed [23:0] b_m [4][4];
    logic signed [23:0] c_m [4][4];
    logic signed [23:0] x0 [4];
    logic signed [23:0] xs [4];
    logic [15:0] steps;
    logic [2:0] n_st, n_in, n_out;
    yword_t pending [$];
    int errors;

    function new();
      for (int i = 0; i < 4; i++) begin
        x0[i] = 0;
        xs[i] = 0;
        for (int j = 0; j < 4; j++) begin
          a_m[i][j] = 0;
          b_m[i][j] = 0;
          c_m[i][j] = 0;
        end
      end
      steps = 0;
      n_st = 4;
      n_in = 4;
      n_out = 4;
      errors = 0;
    endfunction

    function int eff(logic [2:0] r);
      if (r == 0) return 1;
      if (r > 4) return 4;
      return r;
    endfunction

    // Product rounded half up to 12 fractional bits; >>> is a floor.
    function longint rmul(logic signed [23:0] a, logic signed [23:0] b);
      longint p;
      p = longint'(a) * longint'(b) + 2048;
      return p >>> 12;
    endfunction

    function logic signed [23:0] clip(longint v);
      if (v > 8388607) return 24'sh7FFFFF;
      if (v < -8388608) return 24'sh800000;
      return v[23:0];
    endfunction

    function void output_vector();
      yword_t w;
      longint acc;
      for (int k = 0; k < 4; k++) begin
        acc = 0;
        if (k < eff(n_out)) begin
          for (int j = 0; j < eff(n_st); j++) acc += rmul(c_m[k][j], xs[j]);
        end
        w.y[k] = clip(acc);
      end
      w.ts = steps;
      pending = {pending, w};
    endfunction

    function void note_input(op_t op, bank_t bk, logic [1:0] r, logic [1:0] c,
                             logic signed [23:0] v, logic signed [23:0] u [4]);
      logic signed [23:0] nx [4];
      longint acc;
      case (op)
        OP_WRITE: begin
          case (bk)
            BANK_A: a_m[r][c] = v;
            BANK_B: b_m[r][c] = v;
            BANK_C: c_m[r][c] = v;
            default: x0[r] = v;
          endcase
        end
        OP_RESTART: begin
          for (int i = 0; i < 4; i++) xs[i] = (i < eff(n_st)) ? x0[i] : 24'sd0;
          steps = 0;
          output_vector();
        end
        OP_STEP: begin
          for (int i = 0; i < 4; i++) begin
            acc = 0;
            if (i < eff(n_st)) begin
              for (int j = 0; j < eff(n_st); j++) acc += rmul(a_m[i][j], xs[j]);
              for (int j = 0; j < eff(n_in); j++) acc += rmul(b_m[i][j], u[j]);
            end
            nx[i] = clip(acc);
          end
          xs = nx;
          steps++;
          output_vector();
        end
        default: ;
      endcase
    endfunction

    function void check_output(yword_t got);
      yword_t w;
      bit bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output word ts=%0d", got.ts);
        return;
      end
      w = pending.pop_front();
      bad = (w.ts != got.ts);
      for (int k = 0; k < 4; k++) if (w.y[k] !== got.y[k]) bad = 1;
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp y=%0d %0d %0d %0d ts=%0d, got y=%0d %0d %0d %0d ts=%0d",
                   w.y[0], w.y[1], w.y[2], w.y[3], w.ts,
                   got.y[0], got.y[1], got.y[2], got.y[3], got.ts);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid, pready;
  logic [1:0] op = 0, coef_bank = 0, coef_row = 0, coef_col = 0;
  q_t coef_value = 0, u0 = 0, u1 = 0, u2 = 0, u3 = 0;
  q_t y0, y1, y2, y3;
  logic [15:0] time_step;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  ss_scoreboard sb = new();
  longint cycles = 0;
  bit long_hold = 0;

  state_space_system_step_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // The run is bounded: about 800 words, plus random gaps and stalls, fits far
  // inside this limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("** state_space_system_step_unit: FAILED **");
      $finish;
    end
  end

  // Output side: accept words and check them; stall on a pattern of its own,
  // with one long hold-off so that the block backs up and stalls its input.
  always @(posedge clk) begin
    yword_t g;
    if (!rst && out_valid && !out_stall) begin
      g.y[0] = y0; g.y[1] = y1; g.y[2] = y2; g.y[3] = y3;
      g.ts = time_step;
      sb.check_output(g);
    end
    if (long_hold) out_stall <= 1;
    else if (cycles % 600 < 200) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    #30000;
    long_hold = 1;
    repeat (300) @(posedge clk);
    long_hold = 0;
  end

  // Registers are written only with nothing in flight.
  task automatic reg_write(reg_idx_t idx, logic [2:0] v);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= 4'(4 * idx); pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_STATES: sb.n_st = v;
      REG_INPUTS: sb.n_in = v;
      REG_OUTPUTS: sb.n_out = v;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  int burst = 0;

  // Offers one word and holds it until it is accepted; gaps come between bursts.
  // Called right at the edge that accepted the previous word, so valid drops
  // at once when a gap starts.
  task automatic send(op_t o, bank_t bk, logic [1:0] r, logic [1:0] c, q_t v,
                      q_t a, q_t b, q_t d, q_t e);
    q_t u [4];
    if (burst == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst = $urandom_range(1, 12);
    end
    burst--;
    op <= o; coef_bank <= bk; coef_row <= r; coef_col <= c; coef_value <= v;
    u0 <= a; u1 <= b; u2 <= d; u3 <= e;
    in_valid <= 1;
    u[0] = a; u[1] = b; u[2] = d; u[3] = e;
    do @(posedge clk); while (in_stall);
    sb.note_input(o, bk, r, c, v, u);
  endtask

  function automatic q_t rq();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return q_t'($urandom_range(0, 8191)) - 24'sd4096;
      default: return q_t'($urandom);
    endcase
  endfunction

  // Small coefficients keep long runs of steps from pinning at the rails.
  function automatic q_t small_coef();
    return q_t'($urandom_range(0, 4095)) - 24'sd2048;
  endfunction

  task automatic random_word();
    int k;
    k = $urandom_range(0, 19);
    if (k < 6)
      send(OP_WRITE, bank_t'(2'($urandom_range(0, 3))), 2'($urandom), 2'($urandom),
           (k < 4) ? small_coef() : rq(), 0, 0, 0, 0);
    else if (k == 6)
      send(OP_RESTART, bank_t'(2'($urandom)), 2'($urandom), 2'($urandom),
           rq(), rq(), rq(), rq(), rq());
    else if (k == 7)
      send(OP_NONE, bank_t'(2'($urandom)), 2'($urandom), 2'($urandom),
           rq(), rq(), rq(), rq(), rq());
    else
      send(OP_STEP, bank_t'(2'($urandom)), 2'($urandom), 2'($urandom),
           rq(), rq(), rq(), rq(), rq());
  endtask

  initial begin
    logic [2:0] ns, ni, no;
    repeat (10) @(posedge clk);
    rst <= 0;

    // Directed: extremes of the store, restart, step, unused op.
    send(OP_WRITE, BANK_A, 0, 0, 24'sh7FFFFF, 0, 0, 0, 0);
    send(OP_WRITE, BANK_A, 3, 3, 24'sh800000, 0, 0, 0, 0);
    send(OP_WRITE, BANK_B, 0, 3, 24'sh001000, 0, 0, 0, 0);
    send(OP_WRITE, BANK_B, 3, 0, 24'sh800000, 0, 0, 0, 0);
    send(OP_WRITE, BANK_C, 0, 0, 24'sh001000, 0, 0, 0, 0);
    send(OP_WRITE, BANK_C, 3, 3, 24'sh7FFFFF, 0, 0, 0, 0);
    send(OP_WRITE, BANK_C, 1, 3, 24'sh000800, 0, 0, 0, 0);
    send(OP_WRITE, BANK_X0, 0, 3, 24'sh7FFFFF, 0, 0, 0, 0);
    send(OP_WRITE, BANK_X0, 3, 0, 24'sh800000, 0, 0, 0, 0);
    send(OP_RESTART, BANK_A, 0, 0, 0, 0, 0, 0, 0);
    send(OP_STEP, BANK_A, 0, 0, 0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
    send(OP_STEP, BANK_X0, 3, 3, 24'shFFFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh000001,
         24'shFFFFFF);
    send(OP_NONE, BANK_X0, 3, 3, 24'sh7FFFFF, 1, 1, 1, 1);
    send(OP_STEP, BANK_B, 1, 2, 0, 24'sh000800, 24'shFFF800, 0, 0);
    send(OP_RESTART, BANK_C, 2, 1, 0, 0, 0, 0, 0);
    in_valid <= 0;
    burst = 0;
    drain();

    // Several register settings, the extremes (0, 1, 4, 7) among them.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin ns = 0; ni = 0; no = 0; end
        1: begin ns = 7; ni = 7; no = 7; end
        2: begin ns = 1; ni = 4; no = 1; end
        3: begin ns = 4; ni = 1; no = 4; end
        default: begin
          ns = 3'($urandom); ni = 3'($urandom); no = 3'($urandom);
        end
      endcase
      reg_write(REG_STATES, ns);
      reg_write(REG_INPUTS, ni);
      reg_write(REG_OUTPUTS, no);
      send(OP_RESTART, BANK_A, 0, 0, 0, 0, 0, 0, 0);
      for (int n = 0; n < 75; n++) random_word();
      in_valid <= 0;
      burst = 0;
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** state_space_system_step_unit: PASSED **");
    else
      $display("** state_space_system_step_unit: FAILED **");
    $finish;
  end
endmodule

// ===== state_space_system_step_unit.f =====
hdl/sss_pkg.sv
hdl/sss_lane.sv
hdl/state_space_system_step_unit.sv
verif/tb.sv
